>>> design/lfpd_pkg.sv
// shared types and constants of the line follower drive block
`timescale 1ns / 1ps

package lfpd_pkg;

	localparam int READ_W    = 12;
	localparam int SUM_W     = READ_W + 1;
	localparam int QUO_W     = 15;
	localparam int ERR_W     = 20;
	localparam int LAST_W    = 16;
	localparam int BASE_W    = 12;
	localparam int THR_W     = 12;
	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DUTY_W    = 11;
	localparam int GB_W      = GAIN_W + BASE_W;
	localparam int PROD_W    = GB_W + ERR_W;
	localparam int P_SHIFT   = 23;
	localparam int PM_W      = PROD_W - P_SHIFT;
	localparam int SPD_W     = PM_W + 2;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam int ERR_MAX = 524287;
	localparam int ERR_MIN = -524288;

	localparam logic [BASE_W-1:0] BASE_RST = 12'd1000;
	localparam logic [THR_W-1:0]  THR_RST  = 12'd100;
	localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_SPEED = 2'd0,
		CFG_THRESHOLD  = 2'd1,
		CFG_GAIN       = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ERR,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic err_latch;
		logic mul_latch;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic online;
	} status_t;

endpackage

>>> design/line_follow_p_drive.sv
// top level of the proportional line follower with differential drive outputs
`timescale 1ns / 1ps

// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------------
// input    | in_valid/in_stall  | left_reading, right_reading
// output   | out_valid/out_stall| left/right forward/backward duty, on_line, steer_error
// config   | cfg_we             | cfg_index, cfg_data (base_speed, line_threshold, gain)
//
// an on-line word goes through the accepting cycle, 15 steps of the restoring
// divider, then error select, gain multiply and duty split into the output register
// an off-line word leaves the divider state without a step and goes on to error
// select, gain multiply and duty split
// one word is in flight at a time; the next is taken once the result is in the
// output register, even while that register is still stalled
// a stalled output register with a new result ready holds the sequencer until it drains
// reset returns the sequencer, the config registers (to their defaults) and the last
// on-line error to their initial state

module line_follow_p_drive #(
	parameter int DUTY_LIMIT    = 1600,
	parameter int OFFLINE_BOOST = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_we,
	input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfpd_pkg::CFG_W-1:0]        cfg_data,
	// sensor word in
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lfpd_pkg::READ_W-1:0]       left_reading,
	input  logic [lfpd_pkg::READ_W-1:0]       right_reading,
	// drive word out
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lfpd_pkg::DUTY_W-1:0]       left_forward_duty,
	output logic [lfpd_pkg::DUTY_W-1:0]       left_backward_duty,
	output logic [lfpd_pkg::DUTY_W-1:0]       right_forward_duty,
	output logic [lfpd_pkg::DUTY_W-1:0]       right_backward_duty,
	output logic                              on_line,
	output logic signed [lfpd_pkg::ERR_W-1:0] steer_error
);

	// command and status between sequencer and datapath
	lfpd_pkg::cmd_t    cmd;
	lfpd_pkg::status_t status;

	lfpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// config registers, divider, error select, multiplier and the output register
	lfpd_datapath #(
		.DUTY_LIMIT    (DUTY_LIMIT),
		.OFFLINE_BOOST (OFFLINE_BOOST)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.left_reading        (left_reading),
		.right_reading       (right_reading),
		.cmd                 (cmd),
		.status              (status),
		.left_forward_duty   (left_forward_duty),
		.left_backward_duty  (left_backward_duty),
		.right_forward_duty  (right_forward_duty),
		.right_backward_duty (right_backward_duty),
		.on_line             (on_line),
		.steer_error         (steer_error)
	);

endmodule

>>> design/lfpd_ctrl.sv
// sequencer: accepts a word, steps the divider, drives the output handshake
`timescale 1ns / 1ps

module lfpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  lfpd_pkg::status_t status,
	output lfpd_pkg::cmd_t    cmd
);

	lfpd_pkg::state_t state_q, state_d;
	logic [lfpd_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfpd_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			lfpd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cnt_d    = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = lfpd_pkg::ST_DIV;
				end
			end
			lfpd_pkg::ST_DIV: begin
				if (!status.online) begin
					state_d = lfpd_pkg::ST_ERR;
				end else begin
					cmd.div_step = 1'b1;
					if (cnt_q == lfpd_pkg::CNT_W'(lfpd_pkg::DIV_STEPS - 1)) begin
						cnt_d   = '0;
						state_d = lfpd_pkg::ST_ERR;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			lfpd_pkg::ST_ERR: begin
				cmd.err_latch = 1'b1;
				state_d       = lfpd_pkg::ST_MUL;
			end
			lfpd_pkg::ST_MUL: begin
				cmd.mul_latch = 1'b1;
				state_d       = lfpd_pkg::ST_DONE;
			end
			lfpd_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = lfpd_pkg::ST_IDLE;
				end
			end
			default: state_d = lfpd_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/lfpd_datapath.sv
// datapath: config registers, serial divider, error select, gain multiply, duty split
`timescale 1ns / 1ps

module lfpd_datapath #(
	parameter int DUTY_LIMIT    = 1600,
	parameter int OFFLINE_BOOST = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfpd_pkg::CFG_W-1:0]       cfg_data,
	input  logic [lfpd_pkg::READ_W-1:0]      left_reading,
	input  logic [lfpd_pkg::READ_W-1:0]      right_reading,
	input  lfpd_pkg::cmd_t                   cmd,
	output lfpd_pkg::status_t                status,
	output logic [lfpd_pkg::DUTY_W-1:0]      left_forward_duty,
	output logic [lfpd_pkg::DUTY_W-1:0]      left_backward_duty,
	output logic [lfpd_pkg::DUTY_W-1:0]      right_forward_duty,
	output logic [lfpd_pkg::DUTY_W-1:0]      right_backward_duty,
	output logic                             on_line,
	output logic signed [lfpd_pkg::ERR_W-1:0] steer_error
);

	localparam int BOOST_W = $clog2(OFFLINE_BOOST + 1);
	localparam int BP_W    = 21 + BOOST_W;
	localparam int SPD_W   = lfpd_pkg::SPD_W;

	// configuration
	logic [lfpd_pkg::BASE_W-1:0] base_q;
	logic [lfpd_pkg::THR_W-1:0]  thr_q;
	logic [lfpd_pkg::GAIN_W-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= lfpd_pkg::BASE_RST;
			thr_q  <= lfpd_pkg::THR_RST;
			gain_q <= lfpd_pkg::GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lfpd_pkg::CFG_BASE_SPEED: base_q <= cfg_data[lfpd_pkg::BASE_W-1:0];
				lfpd_pkg::CFG_THRESHOLD:  thr_q  <= cfg_data[lfpd_pkg::THR_W-1:0];
				lfpd_pkg::CFG_GAIN:       gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// last on-line error
	logic signed [lfpd_pkg::LAST_W-1:0] last_q;

	// working registers
	logic                          online_q;
	logic                          neg_q;
	logic [lfpd_pkg::SUM_W-1:0]    sum_q;
	logic [lfpd_pkg::SUM_W-1:0]    rem_q;
	logic [lfpd_pkg::QUO_W-1:0]    dlow_q;
	logic [lfpd_pkg::QUO_W-1:0]    quo_q;
	logic [lfpd_pkg::GB_W-1:0]     gb_q;
	logic signed [lfpd_pkg::ERR_W-1:0] err_q;
	logic [lfpd_pkg::PROD_W-1:0]   prod_q;

	// load-time terms
	logic                        online_d;
	logic [lfpd_pkg::READ_W-1:0] mag;
	logic [lfpd_pkg::GB_W-1:0]   gb;

	assign online_d = !(left_reading <= thr_q && right_reading <= thr_q);
	assign mag = (left_reading >= right_reading) ? (left_reading - right_reading)
	                                             : (right_reading - left_reading);
	assign gb = gain_q * base_q;

	// one restoring division step per cycle
	logic [lfpd_pkg::SUM_W:0] trial;
	logic [lfpd_pkg::SUM_W:0] trial_sub;
	logic                     trial_ge;

	assign trial     = {rem_q, dlow_q[lfpd_pkg::QUO_W-1]};
	assign trial_ge  = trial >= {1'b0, sum_q};
	assign trial_sub = trial - {1'b0, sum_q};

	// error select
	logic signed [lfpd_pkg::ERR_W-1:0] quo_ext;
	logic signed [lfpd_pkg::ERR_W-1:0] quo_signed;
	logic signed [BP_W-1:0]            boost_prod;
	logic signed [lfpd_pkg::ERR_W-1:0] boost_sat;

	assign quo_ext    = $signed({{(lfpd_pkg::ERR_W - lfpd_pkg::QUO_W){1'b0}}, quo_q});
	assign quo_signed = neg_q ? -quo_ext : quo_ext;
	assign boost_prod = BP_W'(last_q) * $signed({1'b0, BOOST_W'(OFFLINE_BOOST)});

	always_comb begin
		if (boost_prod > $signed(BP_W'(lfpd_pkg::ERR_MAX)))
			boost_sat = $signed(lfpd_pkg::ERR_W'(lfpd_pkg::ERR_MAX));
		else if (boost_prod < $signed(BP_W'(lfpd_pkg::ERR_MIN)))
			boost_sat = $signed(lfpd_pkg::ERR_W'(lfpd_pkg::ERR_MIN));
		else
			boost_sat = boost_prod[lfpd_pkg::ERR_W-1:0];
	end

	// gain * base * |error|
	logic [lfpd_pkg::ERR_W-1:0]  emag;
	logic [lfpd_pkg::PROD_W-1:0] prod;

	assign emag = err_q[lfpd_pkg::ERR_W-1] ? 20'(-err_q) : 20'(err_q);
	assign prod = gb_q * emag;

	// wheel speeds
	logic [lfpd_pkg::PM_W-1:0] pm;
	logic signed [SPD_W-1:0]   p_s;
	logic signed [SPD_W-1:0]   base_s;
	logic signed [SPD_W-1:0]   left_spd;
	logic signed [SPD_W-1:0]   right_spd;
	logic [2*lfpd_pkg::DUTY_W-1:0] left_split;
	logic [2*lfpd_pkg::DUTY_W-1:0] right_split;

	assign pm        = prod_q[lfpd_pkg::PROD_W-1:lfpd_pkg::P_SHIFT];
	assign base_s    = $signed({{(SPD_W - lfpd_pkg::BASE_W){1'b0}}, base_q});
	assign p_s       = err_q[lfpd_pkg::ERR_W-1] ? -$signed({2'b00, pm}) : $signed({2'b00, pm});
	assign left_spd  = base_s - p_s;
	assign right_spd = base_s + p_s;

	// {forward, backward}; zero speed gives zero on both
	function automatic logic [2*lfpd_pkg::DUTY_W-1:0] split_duty(
		input logic signed [SPD_W-1:0] spd
	);
		logic signed [SPD_W-1:0] m;
		logic signed [SPD_W-1:0] lim;
		logic signed [SPD_W-1:0] c;
		lim = $signed(SPD_W'(DUTY_LIMIT));
		m   = (spd > 0) ? spd : -spd;
		c   = (m < lim) ? m : lim;
		if (spd > 0)
			split_duty = {c[lfpd_pkg::DUTY_W-1:0], {lfpd_pkg::DUTY_W{1'b0}}};
		else
			split_duty = {{lfpd_pkg::DUTY_W{1'b0}}, c[lfpd_pkg::DUTY_W-1:0]};
	endfunction

	assign left_split  = split_duty(left_spd);
	assign right_split = split_duty(right_spd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (cmd.err_latch && online_q) begin
			last_q <= quo_signed[lfpd_pkg::LAST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			online_q <= online_d;
			neg_q    <= left_reading < right_reading;
			sum_q    <= {1'b0, left_reading} + {1'b0, right_reading};
			rem_q    <= lfpd_pkg::SUM_W'(mag[lfpd_pkg::READ_W-1:1]);
			dlow_q   <= {mag[0], {(lfpd_pkg::QUO_W - 1){1'b0}}};
			quo_q    <= '0;
			gb_q     <= gb;
		end
		if (cmd.div_step) begin
			rem_q  <= trial_ge ? trial_sub[lfpd_pkg::SUM_W-1:0] : trial[lfpd_pkg::SUM_W-1:0];
			dlow_q <= {dlow_q[lfpd_pkg::QUO_W-2:0], 1'b0};
			quo_q  <= {quo_q[lfpd_pkg::QUO_W-2:0], trial_ge};
		end
		if (cmd.err_latch)
			err_q <= online_q ? quo_signed : boost_sat;
		if (cmd.mul_latch)
			prod_q <= prod;
		if (cmd.out_load) begin
			left_forward_duty   <= left_split[2*lfpd_pkg::DUTY_W-1:lfpd_pkg::DUTY_W];
			left_backward_duty  <= left_split[lfpd_pkg::DUTY_W-1:0];
			right_forward_duty  <= right_split[2*lfpd_pkg::DUTY_W-1:lfpd_pkg::DUTY_W];
			right_backward_duty <= right_split[lfpd_pkg::DUTY_W-1:0];
			on_line             <= online_q;
			steer_error         <= err_q;
		end
	end

	assign status.online = online_q;

endmodule

>>> design/lfpd_checker.sv
// port-level checks of the line follower drive block and their bind
`timescale 1ns / 1ps

module lfpd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [lfpd_pkg::DUTY_W-1:0]       left_forward_duty,
	input logic [lfpd_pkg::DUTY_W-1:0]       left_backward_duty,
	input logic [lfpd_pkg::DUTY_W-1:0]       right_forward_duty,
	input logic [lfpd_pkg::DUTY_W-1:0]       right_backward_duty,
	input logic                              on_line,
	input logic signed [lfpd_pkg::ERR_W-1:0] steer_error
);

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// one word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted again in the cycle after an accept");

	// a wheel never drives forward and backward together
	a_duty_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_forward_duty == '0 || left_backward_duty == '0) &&
		              (right_forward_duty == '0 || right_backward_duty == '0))
		else $error("forward and backward duty both nonzero");

	// on-line error is a ratio of magnitude at most one
	a_online_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && on_line |-> (steer_error <= 20'sd16384 && steer_error >= -20'sd16384))
		else $error("on-line steering error out of range");

endmodule

bind line_follow_p_drive lfpd_checker u_lfpd_checker (.*);

>>> tb/testbench.sv
// self-checking testbench for the line follower drive block, directed table then random words
`timescale 1ns / 1ps

module testbench;

	localparam int DUTY_CAP      = 1600;
	localparam int BOOST         = 20;
	localparam int SETTLE_CYCLES = 24;      // longer than the longest word's trip through the sequencer, plus margin
	localparam int END_CYCLES    = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 128;
	localparam int REPORT_CAP    = 100;

	// index with no register behind it, the write must be dropped
	localparam logic [lfpd_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_RUNS
	} stall_mode_t;

	typedef enum logic {
		ROW_WORD,
		ROW_WRITE
	} row_kind_t;

	// one drive word as it leaves the block
	typedef struct packed {
		logic [lfpd_pkg::DUTY_W-1:0]       lf;
		logic [lfpd_pkg::DUTY_W-1:0]       lb;
		logic [lfpd_pkg::DUTY_W-1:0]       rf;
		logic [lfpd_pkg::DUTY_W-1:0]       rb;
		logic                              online;
		logic signed [lfpd_pkg::ERR_W-1:0] err;
	} drive_word_t;

	// one line of the directed table: a sensor word or a register write
	typedef struct {
		row_kind_t                      kind;
		logic [lfpd_pkg::READ_W-1:0]    l;
		logic [lfpd_pkg::READ_W-1:0]    r;
		logic [lfpd_pkg::CFG_IDX_W-1:0] idx;
		logic [lfpd_pkg::CFG_W-1:0]     data;
		logic                           typed;
		drive_word_t                    want;
	} plan_row_t;

	logic                                 clk;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_we = 1'b0;
	logic [lfpd_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [lfpd_pkg::CFG_W-1:0]           cfg_data = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic [lfpd_pkg::READ_W-1:0]          left_reading = '0;
	logic [lfpd_pkg::READ_W-1:0]          right_reading = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic [lfpd_pkg::DUTY_W-1:0]          left_forward_duty;
	logic [lfpd_pkg::DUTY_W-1:0]          left_backward_duty;
	logic [lfpd_pkg::DUTY_W-1:0]          right_forward_duty;
	logic [lfpd_pkg::DUTY_W-1:0]          right_backward_duty;
	logic                                 on_line;
	logic signed [lfpd_pkg::ERR_W-1:0]    steer_error;

	// shadow of the block's config registers and last on-line error
	logic [lfpd_pkg::BASE_W-1:0]          base_reg = lfpd_pkg::BASE_RST;
	logic [lfpd_pkg::THR_W-1:0]           thr_reg = lfpd_pkg::THR_RST;
	logic [lfpd_pkg::GAIN_W-1:0]          gain_reg = lfpd_pkg::GAIN_RST;
	logic signed [lfpd_pkg::LAST_W-1:0]   last_err = '0;

	drive_word_t                expected_drive[$];
	plan_row_t                  plan[$];

	stall_mode_t                stall_mode = STALL_NONE;
	int                         stall_run = 0;
	logic                       stall_level = 1'b0;

	int unsigned                cycles = 0;
	int                         errors = 0;
	int                         words_checked = 0;
	int                         offline_seen = 0;
	int                         reverse_seen = 0;
	int                         reg_writes = 0;
	int                         drains = 0;

	line_follow_p_drive #(
		.DUTY_LIMIT   (DUTY_CAP),
		.OFFLINE_BOOST(BOOST)
	) dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.left_reading       (left_reading),
		.right_reading      (right_reading),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.left_forward_duty  (left_forward_duty),
		.left_backward_duty (left_backward_duty),
		.right_forward_duty (right_forward_duty),
		.right_backward_duty(right_backward_duty),
		.on_line            (on_line),
		.steer_error        (steer_error)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending", cycles,
				expected_drive.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// sign split of one wheel speed, magnitude clamped then cut to the port width
	function automatic void split_speed(input longint spd,
		output logic [lfpd_pkg::DUTY_W-1:0] fwd, output logic [lfpd_pkg::DUTY_W-1:0] bwd);
		longint mag;
		mag = (spd < 0) ? -spd : spd;
		if (mag > DUTY_CAP)
			mag = DUTY_CAP;
		if (spd > 0) begin
			fwd = lfpd_pkg::DUTY_W'(mag);
			bwd = '0;
		end else begin
			fwd = '0;
			bwd = lfpd_pkg::DUTY_W'(mag);
		end
	endfunction

	// steering error, pull and wheel duties for one sensor pair; updates the
	// remembered on-line error
	function automatic drive_word_t predict_drive(input logic [lfpd_pkg::READ_W-1:0] l,
		input logic [lfpd_pkg::READ_W-1:0] r);
		drive_word_t w;
		logic        seen;
		longint      diff;
		longint      sum;
		longint      q;
		longint      e;
		longint      emag;
		longint      pull;
		seen = (l > thr_reg) || (r > thr_reg);
		if (seen) begin
			diff = longint'(l) - longint'(r);
			sum = longint'(l) + longint'(r);
			// quotient truncated toward zero, sum is nonzero here
			q = (((diff < 0) ? -diff : diff) * 16384) / sum;
			e = (diff < 0) ? -q : q;
			last_err = lfpd_pkg::LAST_W'(e);
		end else begin
			e = BOOST * longint'(last_err);
			if (e > lfpd_pkg::ERR_MAX)
				e = lfpd_pkg::ERR_MAX;
			if (e < lfpd_pkg::ERR_MIN)
				e = lfpd_pkg::ERR_MIN;
		end
		emag = (e < 0) ? -e : e;
		pull = (longint'(gain_reg) * emag * longint'(base_reg)) >> lfpd_pkg::P_SHIFT;
		if (e < 0)
			pull = -pull;
		split_speed(longint'(base_reg) - pull, w.lf, w.lb);
		split_speed(longint'(base_reg) + pull, w.rf, w.rb);
		w.online = seen;
		w.err = lfpd_pkg::ERR_W'(e);
		return w;
	endfunction

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic report(input string msg);
		if (errors < REPORT_CAP)
			$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %0d want %0d", name, $signed(got), $signed(want)));
	endtask

	// drive word checker, one word per accepting edge
	always @(posedge clk) begin : check_out
		drive_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_drive.size() == 0) begin
				report("drive word with nothing pending");
			end else begin
				want = expected_drive.pop_front();
				check_field("left_forward_duty", left_forward_duty, want.lf);
				check_field("left_backward_duty", left_backward_duty, want.lb);
				check_field("right_forward_duty", right_forward_duty, want.rf);
				check_field("right_backward_duty", right_backward_duty, want.rb);
				check_field("on_line", on_line, want.online);
				check_field("steer_error", steer_error, want.err);
				words_checked++;
				if (!want.online)
					offline_seen++;
				if (want.lb != 0 || want.rb != 0)
					reverse_seen++;
			end
		end
	end

	// receiver stall pattern, independent of the sender
	always @(posedge clk) begin
		case (stall_mode)
			STALL_NONE: begin
				out_stall <= 1'b0;
			end
			STALL_LIGHT: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			STALL_HEAVY: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				// long alternating runs of stall and flow
				if (stall_run == 0) begin
					stall_run = $urandom_range(1, 30);
					stall_level = ~stall_level;
				end
				stall_run--;
				out_stall <= stall_level;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------

	// hold one sensor word until taken, then log what should come back
	task automatic send_word(input logic [lfpd_pkg::READ_W-1:0] l,
		input logic [lfpd_pkg::READ_W-1:0] r, input logic typed, input drive_word_t want);
		drive_word_t pred;
		left_reading <= l;
		right_reading <= r;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		pred = predict_drive(l, r);
		expected_drive.push_back(typed ? want : pred);
	endtask

	// sender gap, valid only lowered when the gap is real
	task automatic rest(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every pending word is back
	task automatic drain();
		if (expected_drive.size() != 0) begin
			in_valid <= 1'b0;
			while (expected_drive.size() != 0)
				@(posedge clk);
			drains++;
		end
	endtask

	// make the block idle before touching its registers
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lfpd_pkg::CFG_IDX_W-1:0] idx,
		input logic [lfpd_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lfpd_pkg::CFG_BASE_SPEED: base_reg = data[lfpd_pkg::BASE_W-1:0];
			lfpd_pkg::CFG_THRESHOLD:  thr_reg = data[lfpd_pkg::THR_W-1:0];
			lfpd_pkg::CFG_GAIN:       gain_reg = data[lfpd_pkg::GAIN_W-1:0];
			default:                  ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// directed table helpers and random pickers
	// ---------------------------------------------------------------

	function automatic drive_word_t mk_word(input int lf, input int lb, input int rf,
		input int rb, input int online, input int err);
		drive_word_t w;
		w.lf = lfpd_pkg::DUTY_W'(lf);
		w.lb = lfpd_pkg::DUTY_W'(lb);
		w.rf = lfpd_pkg::DUTY_W'(rf);
		w.rb = lfpd_pkg::DUTY_W'(rb);
		w.online = online[0];
		w.err = lfpd_pkg::ERR_W'(err);
		return w;
	endfunction

	function automatic void add_row(input row_kind_t kind, input int a, input int b,
		input logic typed, input drive_word_t want);
		plan_row_t row;
		row.kind = kind;
		row.l = lfpd_pkg::READ_W'(a);
		row.r = lfpd_pkg::READ_W'(b);
		row.idx = lfpd_pkg::CFG_IDX_W'(a);
		row.data = lfpd_pkg::CFG_W'(b);
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	// register value: extremes, nominal, small, anything; junk above narrow registers
	function automatic logic [lfpd_pkg::CFG_W-1:0] pick_setting(input int top,
		input int nominal);
		int v;
		case ($urandom_range(0, 4))
			0:       v = 0;
			1:       v = top;
			2:       v = nominal;
			3:       v = $urandom_range(0, (4 * nominal > top) ? top : 4 * nominal);
			default: v = $urandom_range(0, top);
		endcase
		if (top < 65535)
			v = v | ($urandom_range(0, 15) << 12);
		return lfpd_pkg::CFG_W'(v);
	endfunction

	function automatic logic [lfpd_pkg::READ_W-1:0] pick_reading(input int thr);
		int v;
		case ($urandom_range(0, 7))
			0, 1: v = $urandom_range(0, 4095);
			2, 3: v = $urandom_range(0, thr);
			4: begin
				// right around the threshold
				v = thr + $urandom_range(0, 4) - 2;
				v = (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
			end
			5:       v = $urandom_range(0, 1) * 4095;
			default: v = (thr < 4095) ? $urandom_range(thr + 1, 4095) : 4095;
		endcase
		return lfpd_pkg::READ_W'(v);
	endfunction

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	initial begin
		plan_row_t                   row;
		drive_word_t                 none;
		logic [lfpd_pkg::READ_W-1:0] l;
		logic [lfpd_pkg::READ_W-1:0] r;
		int                          burst_left;
		logic                        gappy;

		none = '0;

		// reset values: base 1000, threshold 100, gain 0.5
		add_row(ROW_WORD, 0, 0, 1'b1, mk_word(1000, 0, 1000, 0, 0, 0));
		add_row(ROW_WORD, 4095, 0, 1'b1, mk_word(500, 0, 1500, 0, 1, 16384));
		add_row(ROW_WORD, 0, 4095, 1'b1, mk_word(1500, 0, 500, 0, 1, -16384));
		// off the line after a full-left error, boosted and clamped both ways
		add_row(ROW_WORD, 0, 0, 1'b1, mk_word(1600, 0, 0, 1600, 0, -327680));
		add_row(ROW_WORD, 4095, 4095, 1'b1, mk_word(1000, 0, 1000, 0, 1, 0));
		// threshold edges and quotients that truncate toward zero
		add_row(ROW_WORD, 101, 100, 1'b0, none);
		add_row(ROW_WORD, 100, 100, 1'b0, none);
		add_row(ROW_WORD, 100, 101, 1'b0, none);
		add_row(ROW_WORD, 200, 101, 1'b0, none);
		add_row(ROW_WORD, 0, 100, 1'b0, none);
		add_row(ROW_WORD, 4095, 1, 1'b0, none);
		add_row(ROW_WORD, 1, 4095, 1'b0, none);
		add_row(ROW_WORD, 'hAAA, 'h555, 1'b0, none);
		add_row(ROW_WORD, 'h555, 'hAAA, 1'b0, none);
		// gain 1.0 pulls the left wheel to exactly zero speed
		add_row(ROW_WRITE, lfpd_pkg::CFG_GAIN, 512, 1'b0, none);
		add_row(ROW_WORD, 4095, 0, 1'b1, mk_word(0, 0, 1600, 0, 1, 16384));
		// zero base speed, no drive at all
		add_row(ROW_WRITE, lfpd_pkg::CFG_BASE_SPEED, 0, 1'b0, none);
		add_row(ROW_WORD, 4095, 0, 1'b1, mk_word(0, 0, 0, 0, 1, 16384));
		// every register at its top, junk above the 12-bit ones
		add_row(ROW_WRITE, lfpd_pkg::CFG_BASE_SPEED, 'hFFFF, 1'b0, none);
		add_row(ROW_WRITE, lfpd_pkg::CFG_GAIN, 'hFFFF, 1'b0, none);
		add_row(ROW_WRITE, lfpd_pkg::CFG_THRESHOLD, 'hFFFF, 1'b0, none);
		add_row(ROW_WORD, 4095, 4095, 1'b1, mk_word(0, 1600, 1600, 0, 0, 327680));
		add_row(ROW_WORD, 4095, 0, 1'b0, none);
		// zero threshold, any nonzero reading sees the line
		add_row(ROW_WRITE, lfpd_pkg::CFG_THRESHOLD, 0, 1'b0, none);
		add_row(ROW_WORD, 0, 1, 1'b0, none);
		add_row(ROW_WORD, 0, 0, 1'b0, none);
		// unused index must leave every register alone
		add_row(ROW_WRITE, CFG_NONE, 0, 1'b0, none);
		add_row(ROW_WORD, 4095, 0, 1'b0, none);
		// zero gain, no pull, both wheels at base speed clamped to the duty cap
		add_row(ROW_WRITE, lfpd_pkg::CFG_GAIN, 0, 1'b0, none);
		add_row(ROW_WORD, 0, 4095, 1'b1, mk_word(1600, 0, 1600, 0, 1, -16384));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part
		stall_mode = STALL_LIGHT;
		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.idx, row.data);
			end else begin
				send_word(row.l, row.r, row.typed, row.want);
				rest($urandom_range(0, 2));
			end
		end

		// random part, one register setting per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == 0) begin
				write_reg(lfpd_pkg::CFG_BASE_SPEED, lfpd_pkg::CFG_W'(lfpd_pkg::BASE_RST));
				write_reg(lfpd_pkg::CFG_THRESHOLD, lfpd_pkg::CFG_W'(lfpd_pkg::THR_RST));
				write_reg(lfpd_pkg::CFG_GAIN, lfpd_pkg::GAIN_RST);
			end else begin
				write_reg(lfpd_pkg::CFG_BASE_SPEED, pick_setting(4095, 1000));
				write_reg(lfpd_pkg::CFG_THRESHOLD, pick_setting(4095, 100));
				write_reg(lfpd_pkg::CFG_GAIN, pick_setting(65535, 256));
				if ($urandom_range(0, 2) == 0)
					write_reg(CFG_NONE, lfpd_pkg::CFG_W'($urandom));
			end
			stall_mode = stall_mode_t'(ph % 4);
			gappy = (ph % 3 != 0);
			burst_left = 0;

			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					if (gappy)
						rest($urandom_range(1, 10));
				end
				burst_left--;
				// now and then let everything come back before the next word
				if ($urandom_range(0, 59) == 0)
					drain();
				if ($urandom_range(0, 3) == 0) begin
					// both sensors off the line
					l = lfpd_pkg::READ_W'($urandom_range(0, thr_reg));
					r = lfpd_pkg::READ_W'($urandom_range(0, thr_reg));
				end else begin
					l = pick_reading(thr_reg);
					r = pick_reading(thr_reg);
				end
				send_word(l, r, 1'b0, none);
			end
		end

		// wind down
		in_valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (expected_drive.size() != 0)
			report($sformatf("%0d drive words never came back", expected_drive.size()));

		$display("checked %0d drive words after %0d register writes, %0d off the line",
			words_checked, reg_writes, offline_seen);
		$display("%0d words drove a wheel backward, sender held for a full drain %0d times",
			reverse_seen, drains);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/lfpd_pkg.sv
design/lfpd_ctrl.sv
design/lfpd_datapath.sv
design/line_follow_p_drive.sv
design/lfpd_checker.sv
tb/testbench.sv
